@@ sv/swos_pkg.sv @@
// Package: register map, field widths and reset values of the order-statistics window.
`timescale 1ns / 1ps
package swos_pkg;
   localparam int WLEN_W = 7;
   localparam int FRAC_W = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;
   localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd32768;
   localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;

   // register index, taken from paddr bit 2
   localparam logic REG_WLEN = 1'b0;
   localparam logic REG_FRAC = 1'b1;
endpackage

@@ sv/sliding_window_order_stats.sv @@
// Top level: sliding window of samples with min, max, mean, percentile and rank.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | opcode, value
//  rsp     | out       | rsp_valid/stall   | min, max, mean, percentile, rank, count, flags
//  csr     | in        | APB psel/penable  | window_length (0x0), percentile_fraction (0x4)
//
// Steps per request: a push checks the window; an eviction reads the arrival RAM, scans
// the sorted RAM with shift-down and rechecks; the insert walks the sorted RAM downward.
// Then come setup, the statistics scan, interpolation (S_PCT, S_PCT2), two shared
// bit-serial divides (mean, rank) and the load of the response. A query skips the push
// steps and goes straight to setup.
// Reset is synchronous; no clearing pass, the RAMs are read only below the count.
// A finished response waits in the output register while the next request is taken;
// a response still stalled there holds the next one in its last state.
// Shrinking the window evicts oldest samples one by one; req_stall is held meanwhile.
`timescale 1ns / 1ps
module sliding_window_order_stats #(
   parameter int WINDOW_DEPTH = 64,
   parameter int SAMPLE_BITS  = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_opcode,
   input  logic signed [SAMPLE_BITS-1:0]           req_value,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]           rsp_min_value,
   output logic signed [SAMPLE_BITS-1:0]           rsp_max_value,
   output logic signed [SAMPLE_BITS-1:0]           rsp_mean_value,
   output logic signed [SAMPLE_BITS-1:0]           rsp_percentile_value,
   output logic [swos_pkg::FRAC_W-1:0]             rsp_rank_fraction,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]       rsp_sample_count,
   output logic                                    rsp_window_full,
   output logic                                    rsp_enough_data,
   output logic                                    rsp_no_data,
   // configuration port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [swos_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [swos_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [swos_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);
   localparam int AW     = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int RK_W   = CNT_W + 16;
   localparam int DIVW   = (SUM_W > RK_W) ? SUM_W : RK_W;
   localparam int DCNT_W = $clog2(DIVW + 1);
   localparam int POS_W  = CNT_W + swos_pkg::FRAC_W;

   typedef enum logic [3:0] {
      S_IDLE, S_EV_RD, S_EV_WAIT, S_EV_SCAN, S_PUSH_CHK, S_INS_SCAN,
      S_ST_INIT, S_ST_SCAN, S_PCT, S_PCT2, S_DIV, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [swos_pkg::WLEN_W-1:0] wlen_ff;
   logic [swos_pkg::FRAC_W-1:0] frac_ff;

   // window state
   logic [CNT_W-1:0]        count_ff;
   logic [AW-1:0]           oldest_ff;
   logic signed [SUM_W-1:0] sum_ff;

   // request under work
   logic                          push_ff;
   logic signed [SAMPLE_BITS-1:0] val_ff;
   logic signed [SAMPLE_BITS-1:0] ev_val_ff;

   // scan control
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] pidx_ff;
   logic             pd_ff;
   logic             found_ff;
   logic             placed_ff;

   // statistics
   logic signed [SAMPLE_BITS-1:0] min_ff, max_ff, lo_ff, hi_ff, mean_ff, pct_ff;
   logic [CNT_W-1:0]              l_ff;
   logic [15:0]                   r_ff;
   logic [CNT_W-1:0]              k_ff;
   logic [swos_pkg::FRAC_W-1:0]   rank_ff;
   logic [DIFF_W+15:0]            p1_ff;
   logic [15:0]                   p2_ff;

   // shared divider
   logic [DIVW-1:0]   num_ff;
   logic [CNT_W:0]    rem_ff;
   logic [DCNT_W-1:0] dstep_ff;
   logic              dsel_ff;
   logic              neg_ff;

   // response registers
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff, rsp_max_ff, rsp_mean_ff, rsp_pct_ff;
   logic [swos_pkg::FRAC_W-1:0]   rsp_rank_ff;
   logic [CNT_W-1:0]              rsp_count_ff;
   logic                          rsp_full_ff, rsp_enough_ff, rsp_none_ff;

   // RAM ports
   logic                   srt_we, arr_we;
   logic [AW-1:0]          srt_waddr, srt_raddr, arr_waddr;
   logic [SAMPLE_BITS-1:0] srt_wdata, arr_wdata, srt_rdata, arr_rdata;
   logic signed [SAMPLE_BITS-1:0] srt_rd, arr_rd;

   logic [CNT_W-1:0] eff_len;
   logic             need_evict;
   logic             shrink;
   logic [CNT_W:0]   tail_sum;
   logic [AW-1:0]    tail;
   logic [CNT_W-1:0] n_cnt;
   logic [swos_pkg::FRAC_W-1:0] frac_sat;
   logic [POS_W-1:0] pos;
   logic [DIFF_W-1:0] diff;
   logic [DIFF_W+15:0] p1_in;
   logic [31:0]       p2_full;
   logic [CNT_W:0]    rem_sh;
   logic              div_geq;
   logic [SUM_W-1:0]  sum_mag;
   logic              csr_wr;

   assign srt_rd = srt_rdata;
   assign arr_rd = arr_rdata;

   // effective window length, clamped to 1..WINDOW_DEPTH
   always_comb begin
      if (wlen_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (32'(wlen_ff) > 32'(WINDOW_DEPTH)) begin
         eff_len = CNT_W'(WINDOW_DEPTH);
      end else begin
         eff_len = CNT_W'(wlen_ff);
      end
   end

   assign need_evict = (count_ff >= eff_len) && (count_ff != '0);
   assign shrink     = count_ff > eff_len;
   assign req_stall  = (state_ff != S_IDLE) || shrink;

   // ring slot after the newest sample
   always_comb begin
      tail_sum = (CNT_W+1)'(oldest_ff) + (CNT_W+1)'(count_ff);
      if (tail_sum >= (CNT_W+1)'(WINDOW_DEPTH)) begin
         tail_sum = tail_sum - (CNT_W+1)'(WINDOW_DEPTH);
      end
      tail = tail_sum[AW-1:0];
   end

   // percentile position n * f
   assign n_cnt    = count_ff - CNT_W'(1);
   assign frac_sat = (frac_ff > swos_pkg::FRAC_ONE) ? swos_pkg::FRAC_ONE : frac_ff;
   assign pos      = POS_W'(n_cnt) * POS_W'(frac_sat);

   // interpolation partial products
   assign diff    = {hi_ff[SAMPLE_BITS-1], hi_ff} - {lo_ff[SAMPLE_BITS-1], lo_ff};
   assign p1_in   = (DIFF_W+16)'(diff >> 16) * (DIFF_W+16)'(r_ff);
   assign p2_full = 32'(16'(diff)) * 32'(r_ff);

   // one restoring divide step
   assign rem_sh  = {rem_ff[CNT_W-1:0], num_ff[DIVW-1]};
   assign div_geq = rem_sh >= {1'b0, count_ff};
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   // RAM control
   always_comb begin
      srt_we    = 1'b0;
      srt_waddr = '0;
      srt_wdata = val_ff;
      srt_raddr = idx_ff[AW-1:0];
      arr_we    = 1'b0;
      arr_waddr = tail;
      arr_wdata = val_ff;
      case (state_ff)
         S_EV_SCAN: begin
            if (pd_ff && found_ff) begin
               srt_we    = 1'b1;
               srt_waddr = AW'(pidx_ff - CNT_W'(1));
               srt_wdata = srt_rd;
            end
         end
         S_PUSH_CHK: begin
            arr_we = !need_evict;
         end
         S_INS_SCAN: begin
            srt_raddr = AW'(idx_ff - CNT_W'(1));
            if (pd_ff && !placed_ff) begin
               srt_we    = 1'b1;
               srt_waddr = AW'(pidx_ff + CNT_W'(1));
               srt_wdata = (srt_rd > val_ff) ? srt_rd : val_ff;
            end else if (!placed_ff && idx_ff == '0) begin
               srt_we    = 1'b1;
               srt_waddr = '0;
            end
         end
         default: begin
         end
      endcase
   end

   swos_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_sorted (
      .clock   (clock),
      .wr_en   (srt_we),
      .wr_addr (srt_waddr),
      .wr_data (srt_wdata),
      .rd_addr (srt_raddr),
      .rd_data (srt_rdata)
   );

   swos_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_arrival (
      .clock   (clock),
      .wr_en   (arr_we),
      .wr_addr (arr_waddr),
      .wr_data (arr_wdata),
      .rd_addr (oldest_ff),
      .rd_data (arr_rdata)
   );

   // configuration port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == swos_pkg::REG_WLEN) ?
                       swos_pkg::CSR_DATA_W'(wlen_ff) : swos_pkg::CSR_DATA_W'(frac_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= swos_pkg::WLEN_RESET;
         frac_ff <= swos_pkg::FRAC_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            swos_pkg::REG_WLEN: wlen_ff <= csr_pwdata[swos_pkg::WLEN_W-1:0];
            swos_pkg::REG_FRAC: frac_ff <= csr_pwdata[swos_pkg::FRAC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         oldest_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pd_ff        <= 1'b0;
         found_ff     <= 1'b0;
         placed_ff    <= 1'b0;
         push_ff      <= 1'b0;
      end else begin
         // drop the response once taken, unless a new one is loaded now
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (shrink) begin
                  push_ff  <= 1'b0;
                  state_ff <= S_EV_RD;
               end else if (req_valid) begin
                  push_ff  <= !req_opcode;
                  val_ff   <= req_value;
                  state_ff <= req_opcode ? S_ST_INIT : S_PUSH_CHK;
               end
            end
            S_EV_RD: begin
               state_ff <= S_EV_WAIT;
            end
            S_EV_WAIT: begin
               ev_val_ff <= arr_rd;
               idx_ff    <= '0;
               pd_ff     <= 1'b0;
               found_ff  <= 1'b0;
               state_ff  <= S_EV_SCAN;
            end
            S_EV_SCAN: begin
               // find the evicted copy, shift later entries down
               if (pd_ff && !found_ff && srt_rd == ev_val_ff) begin
                  found_ff <= 1'b1;
               end
               if (idx_ff == count_ff && !pd_ff) begin
                  sum_ff    <= sum_ff - SUM_W'(ev_val_ff);
                  oldest_ff <= (oldest_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_ff + AW'(1);
                  count_ff  <= count_ff - CNT_W'(1);
                  state_ff  <= push_ff ? S_PUSH_CHK : S_IDLE;
               end else if (idx_ff != count_ff) begin
                  pd_ff   <= 1'b1;
                  pidx_ff <= idx_ff;
                  idx_ff  <= idx_ff + CNT_W'(1);
               end else begin
                  pd_ff <= 1'b0;
               end
            end
            S_PUSH_CHK: begin
               if (need_evict) begin
                  state_ff <= S_EV_RD;
               end else begin
                  idx_ff    <= count_ff;
                  pd_ff     <= 1'b0;
                  placed_ff <= 1'b0;
                  state_ff  <= S_INS_SCAN;
               end
            end
            S_INS_SCAN: begin
               // walk down from the top, shifting larger entries up
               if (pd_ff && !placed_ff && !(srt_rd > val_ff)) begin
                  placed_ff <= 1'b1;
               end
               if (placed_ff || (idx_ff == '0 && !pd_ff)) begin
                  pd_ff    <= 1'b0;
                  sum_ff   <= sum_ff + SUM_W'(val_ff);
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= S_ST_INIT;
               end else if (idx_ff != '0) begin
                  pd_ff   <= 1'b1;
                  pidx_ff <= idx_ff - CNT_W'(1);
                  idx_ff  <= idx_ff - CNT_W'(1);
               end else begin
                  pd_ff <= 1'b0;
               end
            end
            S_ST_INIT: begin
               if (count_ff == '0) begin
                  min_ff   <= '0;
                  max_ff   <= '0;
                  mean_ff  <= '0;
                  pct_ff   <= '0;
                  rank_ff  <= '0;
                  state_ff <= S_OUT;
               end else begin
                  l_ff     <= pos[CNT_W+15:16];
                  r_ff     <= pos[15:0];
                  idx_ff   <= '0;
                  k_ff     <= '0;
                  pd_ff    <= 1'b0;
                  state_ff <= S_ST_SCAN;
               end
            end
            S_ST_SCAN: begin
               // pick off order statistics and count entries at or below the value
               if (pd_ff) begin
                  if (pidx_ff == '0) min_ff <= srt_rd;
                  if (pidx_ff == n_cnt) max_ff <= srt_rd;
                  if (pidx_ff == l_ff) lo_ff <= srt_rd;
                  if (pidx_ff == l_ff + CNT_W'(1)) hi_ff <= srt_rd;
                  if (srt_rd <= val_ff) k_ff <= k_ff + CNT_W'(1);
               end
               if (idx_ff == count_ff && !pd_ff) begin
                  state_ff <= S_PCT;
               end else if (idx_ff != count_ff) begin
                  pd_ff   <= 1'b1;
                  pidx_ff <= idx_ff;
                  idx_ff  <= idx_ff + CNT_W'(1);
               end else begin
                  pd_ff <= 1'b0;
               end
            end
            S_PCT: begin
               p1_ff    <= p1_in;
               p2_ff    <= p2_full[31:16];
               state_ff <= S_PCT2;
            end
            S_PCT2: begin
               // top percentile returns the maximum
               if (l_ff >= n_cnt) begin
                  pct_ff <= max_ff;
               end else begin
                  pct_ff <= lo_ff + SAMPLE_BITS'(p1_ff) + SAMPLE_BITS'(p2_ff);
               end
               num_ff   <= DIVW'(sum_mag);
               neg_ff   <= sum_ff[SUM_W-1];
               rem_ff   <= '0;
               dstep_ff <= '0;
               dsel_ff  <= 1'b0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (dstep_ff == DCNT_W'(DIVW)) begin
                  if (!dsel_ff) begin
                     mean_ff  <= neg_ff ? -SAMPLE_BITS'(num_ff) : SAMPLE_BITS'(num_ff);
                     num_ff   <= DIVW'({k_ff, 16'h0000});
                     rem_ff   <= '0;
                     dstep_ff <= '0;
                     dsel_ff  <= 1'b1;
                  end else begin
                     rank_ff  <= num_ff[swos_pkg::FRAC_W-1:0];
                     state_ff <= S_OUT;
                  end
               end else begin
                  rem_ff   <= div_geq ? rem_sh - {1'b0, count_ff} : rem_sh;
                  num_ff   <= {num_ff[DIVW-2:0], div_geq};
                  dstep_ff <= dstep_ff + DCNT_W'(1);
               end
            end
            S_OUT: begin
               // load the response once the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_min_ff    <= min_ff;
                  rsp_max_ff    <= max_ff;
                  rsp_mean_ff   <= mean_ff;
                  rsp_pct_ff    <= pct_ff;
                  rsp_rank_ff   <= rank_ff;
                  rsp_count_ff  <= count_ff;
                  rsp_full_ff   <= count_ff == eff_len;
                  rsp_enough_ff <= count_ff > CNT_W'(2);
                  rsp_none_ff   <= count_ff == '0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_min_value        = rsp_min_ff;
   assign rsp_max_value        = rsp_max_ff;
   assign rsp_mean_value       = rsp_mean_ff;
   assign rsp_percentile_value = rsp_pct_ff;
   assign rsp_rank_fraction    = rsp_rank_ff;
   assign rsp_sample_count     = rsp_count_ff;
   assign rsp_window_full      = rsp_full_ff;
   assign rsp_enough_data      = rsp_enough_ff;
   assign rsp_no_data          = rsp_none_ff;
endmodule

@@ sv/swos_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module swos_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
